@@ src/qte_pkg.sv @@
// Package for the quaternion to Euler angle pipeline.
// Stage map, word widths, angle constants and the arctangent table.
// No dependencies.
package qte_pkg;

  localparam int PW = 34;
  localparam int CW = 44;
  localparam int ZW = 28;
  localparam int SQ_STEPS = 31;
  localparam int CORDIC_STEPS = 20;
  localparam int NORM_MSB = 40;

  localparam int ST_P0 = 0;
  localparam int ST_P1 = 1;
  localparam int ST_P2 = 2;
  localparam int ST_P3 = 3;
  localparam int ST_Q0 = 4;
  localparam int ST_A0 = ST_Q0 + SQ_STEPS;
  localparam int ST_A1 = ST_A0 + 1;
  localparam int ST_A2 = ST_A0 + 2;
  localparam int ST_C0 = ST_A0 + 3;
  localparam int ST_R = ST_C0 + CORDIC_STEPS;
  localparam int NSTG = ST_R + 1;

  localparam logic signed [PW-1:0] ONE_Q30 = {{(PW-31){1'b0}}, 1'b1, 30'b0};
  localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [ZW-1:0] ROUND_Q24 = 28'sd1024;
  localparam logic signed [ZW-1:0] PI_Q13 = 28'sd25736;
  localparam logic signed [ZW-1:0] HALF_PI_Q13 = 28'sd12868;

  localparam logic signed [ZW-1:0] ATAN_Q24 [0:CORDIC_STEPS-1] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
    28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
    28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024,
    28'sd512, 28'sd256, 28'sd128, 28'sd64, 28'sd32
  };

  typedef struct packed {
    logic signed [PW-1:0] sinr;
    logic signed [PW-1:0] cosr;
    logic signed [PW-1:0] siny;
    logic signed [PW-1:0] cosy;
    logic signed [PW-1:0] sinp;
    logic                 sat;
  } term_t;

  typedef struct packed {
    logic [2:0] zero;
    logic       sat;
    logic       neg;
  } flag_t;

endpackage

@@ src/quaternion_to_euler_angles.sv @@
// Quaternion (Q1.15) to roll, yaw (Q3.13) and pitch (Q2.13) pipeline.
// Products, arcsine cosine by pipelined square root, three CORDIC lanes.
// Depends on qte_pkg.
//
// Input channel: quat_valid / quat_stall with quat_x, quat_y, quat_z,
// quat_w. Output channel: angle_valid / angle_stall with roll_angle,
// pitch_angle, yaw_angle and pitch_saturated. A word moves at a rising
// edge where valid is high and stall is low.
// Throughput: one word per cycle while the receiver does not stall.
// The pipeline has 59 register stages: 4 product/sum stages, 31
// square-root stages, one per root bit, 3 normalize stages, 20 CORDIC
// stages, 1 rounding stage.
// When the receiver stalls, the word at the output holds; stages behind
// it keep advancing into empty slots, so input is taken until every
// stage holds a word. Reset (rst, synchronous) empties the pipeline.
module quaternion_to_euler_angles import qte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               quat_valid,
  output logic               quat_stall,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic               angle_valid,
  input  logic               angle_stall,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic               pitch_saturated
);

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] en;

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      en[k] = !angle_stall || !(&(v | ~({NSTG{1'b1}} << k)));
    end
  end

  assign quat_stall  = !en[0];
  assign angle_valid = v[ST_R];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= quat_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // products
  logic signed [31:0] p_xx, p_yy, p_zz, p_wx, p_yz, p_wz, p_xy, p_wy, p_zx;

  always_ff @(posedge clk) begin
    if (en[ST_P0]) begin
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_zz <= quat_z * quat_z;
      p_wx <= quat_w * quat_x;
      p_yz <= quat_y * quat_z;
      p_wz <= quat_w * quat_z;
      p_xy <= quat_x * quat_y;
      p_wy <= quat_w * quat_y;
      p_zx <= quat_z * quat_x;
    end
  end

  // atan2 operands and arcsine argument
  term_t t1, t2, t3;

  always_ff @(posedge clk) begin
    if (en[ST_P1]) begin
      t1.sinr <= (PW'(p_wx) + PW'(p_yz)) <<< 1;
      t1.cosr <= ONE_Q30 - ((PW'(p_xx) + PW'(p_yy)) <<< 1);
      t1.siny <= (PW'(p_wz) + PW'(p_xy)) <<< 1;
      t1.cosy <= ONE_Q30 - ((PW'(p_yy) + PW'(p_zz)) <<< 1);
      t1.sinp <= (PW'(p_wy) - PW'(p_zx)) <<< 1;
      t1.sat  <= 1'b0;
    end
  end

  logic [PW-1:0] mag1;
  logic [59:0]   sq2;
  logic [60:0]   rem3;
  term_t         t1s;

  assign mag1 = t1.sinp[PW-1] ? PW'(-t1.sinp) : PW'(t1.sinp);

  always_comb begin
    t1s     = t1;
    t1s.sat = (mag1[PW-1:30] != '0);
  end

  always_ff @(posedge clk) begin
    if (en[ST_P2]) begin
      t2  <= t1s;
      sq2 <= mag1[29:0] * mag1[29:0];
    end
    if (en[ST_P3]) begin
      t3   <= t2;
      rem3 <= {1'b1, 60'b0} - {1'b0, sq2};
    end
  end

  // square root, one result bit per stage
  logic [60:0] qn [0:SQ_STEPS-1];
  logic [61:0] qr [0:SQ_STEPS-1];
  term_t       qt [0:SQ_STEPS-1];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam int SH = 2 * (SQ_STEPS - 1 - j);
    logic [60:0] n_in;
    logic [61:0] r_in;
    term_t       t_in;
    logic [62:0] trial;

    if (j == 0) begin : g_first
      assign n_in = rem3;
      assign r_in = '0;
      assign t_in = t3;
    end else begin : g_next
      assign n_in = qn[j-1];
      assign r_in = qr[j-1];
      assign t_in = qt[j-1];
    end

    assign trial = {2'b0, n_in} - ({1'b0, r_in} + (63'(1) << SH));

    always_ff @(posedge clk) begin
      if (en[ST_Q0+j]) begin
        qt[j] <= t_in;
        if (!trial[62]) begin
          qn[j] <= trial[60:0];
          qr[j] <= (r_in >> 1) + (62'(1) << SH);
        end else begin
          qn[j] <= n_in;
          qr[j] <= r_in >> 1;
        end
      end
    end
  end

  // normalize: lanes 0 roll, 1 pitch, 2 yaw
  logic signed [PW-1:0] ys [0:2];
  logic signed [PW-1:0] xs [0:2];
  logic signed [PW-1:0] a0x [0:2];
  logic signed [PW-1:0] a0y [0:2];
  logic [5:0]           a0sh [0:2];
  logic [5:0]           sh0 [0:2];
  logic [2:0]           zero0;
  flag_t                fl [ST_A0:ST_R-1];

  assign ys[0] = qt[SQ_STEPS-1].sinr;
  assign xs[0] = qt[SQ_STEPS-1].cosr;
  assign ys[1] = qt[SQ_STEPS-1].sinp;
  assign xs[1] = {{(PW-31){1'b0}}, qr[SQ_STEPS-1][30:0]};
  assign ys[2] = qt[SQ_STEPS-1].siny;
  assign xs[2] = qt[SQ_STEPS-1].cosy;

  always_comb begin
    logic [PW-1:0] mx, my, o;
    logic [5:0]    pos;
    for (int l = 0; l < 3; l++) begin
      mx  = xs[l][PW-1] ? PW'(-xs[l]) : PW'(xs[l]);
      my  = ys[l][PW-1] ? PW'(-ys[l]) : PW'(ys[l]);
      o   = mx | my;
      pos = '0;
      for (int b = 0; b < PW; b++) begin
        if (o[b]) pos = 6'(b);
      end
      sh0[l]   = 6'(NORM_MSB) - pos;
      zero0[l] = (o == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_A0]) begin
      for (int l = 0; l < 3; l++) begin
        a0x[l]  <= xs[l];
        a0y[l]  <= ys[l];
        a0sh[l] <= sh0[l];
      end
      fl[ST_A0].zero <= zero0;
      fl[ST_A0].sat  <= qt[SQ_STEPS-1].sat;
      fl[ST_A0].neg  <= qt[SQ_STEPS-1].sinp[PW-1];
    end
    for (int k = ST_A1; k < ST_R; k++) begin
      if (en[k]) fl[k] <= fl[k-1];
    end
  end

  logic signed [CW-1:0] a1x [0:2];
  logic signed [CW-1:0] a1y [0:2];
  logic signed [CW-1:0] a2x [0:2];
  logic signed [CW-1:0] a2y [0:2];
  logic signed [ZW-1:0] a2z [0:2];

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      if (en[ST_A1]) begin
        a1x[l] <= CW'(a0x[l]) <<< a0sh[l];
        a1y[l] <= CW'(a0y[l]) <<< a0sh[l];
      end
      if (en[ST_A2]) begin
        if (a1x[l][CW-1]) begin
          if (!a1y[l][CW-1]) begin
            a2x[l] <= a1y[l];
            a2y[l] <= -a1x[l];
            a2z[l] <= HALF_PI_Q24;
          end else begin
            a2x[l] <= -a1y[l];
            a2y[l] <= a1x[l];
            a2z[l] <= -HALF_PI_Q24;
          end
        end else begin
          a2x[l] <= a1x[l];
          a2y[l] <= a1y[l];
          a2z[l] <= '0;
        end
      end
    end
  end

  // CORDIC vectoring
  logic signed [CW-1:0] cx [0:CORDIC_STEPS-1][0:2];
  logic signed [CW-1:0] cy [0:CORDIC_STEPS-1][0:2];
  logic signed [ZW-1:0] cz [0:CORDIC_STEPS-1][0:2];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CW-1:0] xi [0:2];
    logic signed [CW-1:0] yi [0:2];
    logic signed [ZW-1:0] zi [0:2];

    for (genvar l = 0; l < 3; l++) begin : g_lane
      if (i == 0) begin : g_first
        assign xi[l] = a2x[l];
        assign yi[l] = a2y[l];
        assign zi[l] = a2z[l];
      end else begin : g_next
        assign xi[l] = cx[i-1][l];
        assign yi[l] = cy[i-1][l];
        assign zi[l] = cz[i-1][l];
      end

      always_ff @(posedge clk) begin
        if (en[ST_C0+i]) begin
          if (!yi[l][CW-1]) begin
            cx[i][l] <= xi[l] + (yi[l] >>> i);
            cy[i][l] <= yi[l] - (xi[l] >>> i);
            cz[i][l] <= zi[l] + ATAN_Q24[i];
          end else begin
            cx[i][l] <= xi[l] - (yi[l] >>> i);
            cy[i][l] <= yi[l] + (xi[l] >>> i);
            cz[i][l] <= zi[l] - ATAN_Q24[i];
          end
        end
      end
    end
  end

  // round to Q3.13 and clamp
  logic signed [ZW-1:0] ang [0:2];
  flag_t                flr;

  assign flr = fl[ST_R-1];

  always_comb begin
    logic signed [ZW-1:0] r, lim;
    for (int l = 0; l < 3; l++) begin
      lim = (l == 1) ? HALF_PI_Q13 : PI_Q13;
      r   = (cz[CORDIC_STEPS-1][l] + ROUND_Q24) >>> 11;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      if (flr.zero[l]) r = '0;
      ang[l] = r;
    end
    if (flr.sat) ang[1] = flr.neg ? -HALF_PI_Q13 : HALF_PI_Q13;
  end

  always_ff @(posedge clk) begin
    if (en[ST_R]) begin
      roll_angle      <= 16'(ang[0]);
      pitch_angle     <= 15'(ang[1]);
      yaw_angle       <= 16'(ang[2]);
      pitch_saturated <= flr.sat;
    end
  end

endmodule

@@ src/qte_check.sv @@
// Port-level checker for quaternion_to_euler_angles, bound to the top.
// Depends on qte_pkg.
module qte_check import qte_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               quat_valid,
  input logic               quat_stall,
  input logic signed [15:0] quat_x,
  input logic signed [15:0] quat_y,
  input logic signed [15:0] quat_z,
  input logic signed [15:0] quat_w,
  input logic               angle_valid,
  input logic               angle_stall,
  input logic signed [15:0] roll_angle,
  input logic signed [14:0] pitch_angle,
  input logic signed [15:0] yaw_angle,
  input logic               pitch_saturated
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    angle_valid && angle_stall |=> angle_valid)
    else $error("output word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    angle_valid && angle_stall |=> $stable(roll_angle) && $stable(pitch_angle)
      && $stable(yaw_angle) && $stable(pitch_saturated))
    else $error("stalled output word changed");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !angle_valid)
    else $error("output valid right after reset");

  a_sat_pitch: assert property (@(posedge clk) disable iff (rst)
    angle_valid && pitch_saturated |->
      (pitch_angle == 15'(HALF_PI_Q13)) || (pitch_angle == 15'(-HALF_PI_Q13)))
    else $error("saturated pitch not at a pole");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    angle_valid |-> (roll_angle <= 16'sd25736) && (roll_angle >= -16'sd25736)
      && (yaw_angle <= 16'sd25736) && (yaw_angle >= -16'sd25736))
    else $error("roll or yaw out of range");

endmodule

bind quaternion_to_euler_angles qte_check u_qte_check (.*);

@@ tb/sv/testbench.sv @@
// Testbench for quaternion_to_euler_angles: directed and random quaternions
// checked word by word against a fixed-point predictor in a scoreboard.
// Depends on qte_pkg and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               sat;
  } euler_t;

  class euler_scoreboard;
    euler_t angles_due[$];
    int     mismatches = 0;
    int     words_in = 0;
    int     words_out = 0;
    int     sat_seen = 0;

    static function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res = 0;
      longint unsigned bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
        if (n >= res + bit_v) begin
          n = n - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
      return res;
    endfunction

    static function automatic longint cordic_atan2(longint y, longint x, longint lim);
      longint z = 0;
      longint m, t, dx, dy, r;
      longint ay, ax;
      if (x == 0 && y == 0) return 0;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      m = ax > ay ? ax : ay;
      while (m < (64'sd1 <<< qte_pkg::NORM_MSB)) begin
        x = x * 2;
        y = y * 2;
        m = m * 2;
      end
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = qte_pkg::HALF_PI_Q24;
        end else begin
          x = -y;
          y = t;
          z = -qte_pkg::HALF_PI_Q24;
        end
      end
      for (int i = 0; i < qte_pkg::CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + qte_pkg::ATAN_Q24[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - qte_pkg::ATAN_Q24[i];
        end
      end
      r = (z + 1024) >>> 11;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
    endfunction

    function void note_quat(logic signed [15:0] qx, qy, qz, qw);
      longint x = qx, y = qy, z = qz, w = qw;
      longint one = 64'sd1 <<< 30;
      longint sinp = 2 * (w * y - z * x);
      longint ms = sinp < 0 ? -sinp : sinp;
      longint unsigned rem;
      euler_t e;
      e.roll = 16'(cordic_atan2(2 * (w * x + y * z), one - 2 * (x * x + y * y), 25736));
      e.yaw = 16'(cordic_atan2(2 * (w * z + x * y), one - 2 * (y * y + z * z), 25736));
      if (ms >= one) begin
        e.pitch = sinp > 0 ? 15'sd12868 : -15'sd12868;
        e.sat = 1'b1;
      end else begin
        rem = (64'd1 << 60) - longint'(sinp * sinp);
        e.pitch = 15'(cordic_atan2(sinp, longint'(int_sqrt(rem)), 12868));
        e.sat = 1'b0;
      end
      angles_due.push_back(e);
      words_in++;
    endfunction

    function void check_angles(logic signed [15:0] roll, logic signed [14:0] pitch,
                               logic signed [15:0] yaw, logic sat);
      euler_t e;
      words_out++;
      if (sat) sat_seen++;
      if (angles_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: roll %0d pitch %0d yaw %0d sat %0b",
                                       roll, pitch, yaw, sat);
        return;
      end
      e = angles_due.pop_front();
      if (roll !== e.roll || pitch !== e.pitch || yaw !== e.yaw || sat !== e.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch word %0d: exp roll %0d pitch %0d yaw %0d sat %0b, got %0d %0d %0d %0b",
                   words_out, e.roll, e.pitch, e.yaw, e.sat, roll, pitch, yaw, sat);
      end
    endfunction

    function int pending();
      return angles_due.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic quat_valid = 0;
  logic quat_stall;
  logic signed [15:0] quat_x = 0, quat_y = 0, quat_z = 0, quat_w = 0;
  logic angle_valid;
  logic angle_stall = 0;
  logic signed [15:0] roll_angle, yaw_angle;
  logic signed [14:0] pitch_angle;
  logic pitch_saturated;

  euler_scoreboard sb = new();
  bit  quiet = 0;
  bit  hold_req = 0;
  int  cycles = 0;

  always #5 clk = ~clk;

  quaternion_to_euler_angles dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && angle_valid && !angle_stall)
      sb.check_angles(roll_angle, pitch_angle, yaw_angle, pitch_saturated);

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        angle_stall <= 1;
        repeat (300) @(posedge clk);
        angle_stall <= 0;
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        angle_stall <= 1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        angle_stall <= 0;
      end
    end
  end

  task automatic send_quat(logic signed [15:0] qx, qy, qz, qw);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      quat_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    quat_valid <= 1;
    quat_x <= qx;
    quat_y <= qy;
    quat_z <= qz;
    quat_w <= qw;
    @(posedge clk);
    while (quat_stall) @(posedge clk);
    sb.note_quat(qx, qy, qz, qw);
  endtask

  task automatic send_unit(real spread);
    real a, b, c, d, n;
    a = ($urandom_range(0, 65535) - 32768.0) / 32768.0;
    b = ($urandom_range(0, 65535) - 32768.0) / 32768.0;
    c = ($urandom_range(0, 65535) - 32768.0) / 32768.0 * spread;
    d = ($urandom_range(0, 65535) - 32768.0) / 32768.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1e-6) begin
      a = 1.0;
      n = 1.0;
    end
    send_quat(16'($rtoi(a / n * 32767.0)), 16'($rtoi(b / n * 32767.0)),
              16'($rtoi(c / n * 32767.0)), 16'($rtoi(d / n * 32767.0)));
  endtask

  initial begin
    logic signed [15:0] e [4] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_quat(0, 0, 0, 0);
    send_quat(0, 0, 0, 32767);
    send_quat(0, 0, 0, -32768);
    send_quat(32767, 0, 0, 0);
    send_quat(0, 32767, 0, 0);
    send_quat(0, 0, 32767, 0);
    send_quat(0, 23170, 0, 23170);
    send_quat(0, -23170, 0, 23170);
    send_quat(-23170, 0, 23170, 0);
    send_quat(0, 23171, 0, 23171);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(23170, 0, 0, -23170);
    send_quat(0, 0, -23170, 23170);
    send_quat(-1, -1, -1, -1);
    send_quat(1, 0, 0, 0);
    send_quat(16384, 16384, 16384, 16384);
    for (int i = 0; i < 4; i++) send_quat(e[i], e[(i + 1) % 4], e[(i + 2) % 4], e[(i + 3) % 4]);

    for (int n = 0; n < 1900; n++) begin
      if (n == 500) hold_req = 1;
      if (n == 1000) begin
        quat_valid <= 0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      if (n == 1700) quiet = 1;
      case ($urandom_range(0, 9))
        0, 1: send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        2: send_unit(0.02);
        default: send_unit(1.0);
      endcase
    end
    quat_valid <= 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("%0d quaternions sent, %0d angle words checked, %0d with pitch clamped",
             sb.words_in, sb.words_out, sb.sat_seen);
    if (sb.mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("testbench failed");
    end
    $finish;
  end
endmodule
